@@ rtl/bba_pkg.sv @@
// package with shared types and constants for the bitmap block allocator
package bba_pkg;

   localparam int NUM_BLOCKS_DEF = 4096;
   localparam int ROW_W = 64;
   localparam int ROW_BW = 6;
   localparam int BLK_W = 12;
   localparam int CNT_W = 13;
   localparam int STAT_W = 3;

   localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE = 1'b1;

   typedef logic [STAT_W-1:0] status_type;

   localparam status_type ST_ALLOCATED = 3'd0;
   localparam status_type ST_FULL = 3'd1;
   localparam status_type ST_FREED = 3'd2;
   localparam status_type ST_ALREADY_FREE = 3'd3;
   localparam status_type ST_OUT_OF_RANGE = 3'd4;

   typedef struct packed {
      logic command;
      logic [BLK_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [BLK_W-1:0] result_block;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic found;
      logic [ROW_BW-1:0] bit_idx;
   } find_type;

endpackage

@@ rtl/bba_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module bba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH < 2) ? 1 : $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bba_find.sv @@
// lowest free bit search over one map row, limited to the blocks in range
module bba_find
   import bba_pkg::*;
#(
   parameter int CMP_W = 17
) (
   input  logic [ROW_W-1:0] row_word,
   input  logic [CMP_W-1:0] remain,
   output find_type         find
);

   logic [ROW_W-1:0] range_mask;
   logic [ROW_W-1:0] free_bits;

   always_comb begin
      if (remain >= CMP_W'(ROW_W)) begin
         range_mask = '1;
      end else begin
         range_mask = (ROW_W'(1) << remain[ROW_BW-1:0]) - ROW_W'(1);
      end
      free_bits = ~row_word & range_mask;
      find.found = |free_bits;
      find.bit_idx = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            find.bit_idx = ROW_BW'(i);
         end
      end
   end

endmodule

@@ rtl/bitmap_block_allocator_top.sv @@
// bitmap block allocator: first-fit allocate and free over a used-bit map in ram
//
// req channel (valid/ready) carries one word: command and block_number.
// rsp channel (valid/ready) returns one word per request: result_block, status.
// csr_wr_en / csr_wr_data write block_count, the search limit; write only when idle.
// the map lives in one ram of 64-bit rows; one row is read per cycle.
// allocate: reads rows from row 0 up until a free bit in range is found,
//   sets it and answers with its block number, or answers full; rows read
//   are at most ceil(limit/64), 64 for a 4096-block map.
// free: one read and, if the block was in use, one write back that clears its bit.
// an allocate with a zero count or an out of range free reads no row and goes to RESP.
// one request is in flight at a time; req_ready is high only while idle, so a new
//   word is taken only after the previous result has gone to the rsp register.
// a finished result sits in the rsp register; the next request is taken while
//   it waits, and its result waits until the receiver takes the earlier word.
// after reset the map is cleared one row per cycle with req_ready low;
//   block_count returns to 4096.
module bitmap_block_allocator_top
   import bba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_word,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   localparam int ROWS = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
   localparam int ROW_AW = (ROWS < 2) ? 1 : $clog2(ROWS);
   localparam int LIM_W = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_A = (LIM_W > CNT_W) ? LIM_W : CNT_W;
   localparam int CMP_W = (CMP_A > ROW_BW + ROW_AW + 1) ? CMP_A : ROW_BW + ROW_AW + 1;

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      SCAN,
      FREE_RD,
      RESP
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [ROW_AW-1:0] row_ff;
   logic [BLK_W-1:0] bn_ff;
   logic [CMP_W-1:0] lim_ff;
   rsp_type pend_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic accept;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] lim_in;
   logic [CMP_W-1:0] req_bn_ext;
   logic [CMP_W-1:0] bn_ext;
   logic [CMP_W-1:0] row_base;
   logic [CMP_W-1:0] remain;
   logic [CMP_W-1:0] grant;
   logic more_rows;
   find_type find;

   logic ram_wr_en;
   logic [ROW_AW-1:0] ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic ram_rd_en;
   logic [ROW_AW-1:0] ram_rd_addr;
   logic [ROW_W-1:0] ram_rd_data;

   assign req_ready = (state_ff == IDLE);
   assign accept = req_valid && req_ready;
   assign count_ext = CMP_W'(count_ff);
   assign lim_in = (count_ext > CMP_W'(NUM_BLOCKS)) ? CMP_W'(NUM_BLOCKS) : count_ext;
   assign req_bn_ext = CMP_W'(req_word.block_number);
   assign bn_ext = CMP_W'(bn_ff);
   assign row_base = CMP_W'(row_ff) << ROW_BW;
   assign remain = lim_ff - row_base;
   assign more_rows = (remain > CMP_W'(ROW_W));
   assign grant = row_base + CMP_W'(find.bit_idx);

   bba_find #(
      .CMP_W(CMP_W)
   ) u_find (
      .row_word(ram_rd_data),
      .remain(remain),
      .find(find)
   );

   bba_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ROWS)
   ) u_map (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      ram_wr_en = 1'b0;
      ram_wr_addr = row_ff;
      ram_wr_data = '0;
      ram_rd_en = 1'b0;
      ram_rd_addr = row_ff;
      unique case (state_ff)
         CLEAR: begin
            ram_wr_en = 1'b1;
         end
         IDLE: begin
            if (req_word.command == CMD_ALLOC) begin
               ram_rd_en = accept && (lim_in != '0);
               ram_rd_addr = '0;
            end else begin
               ram_rd_en = accept && (req_bn_ext < lim_in);
               ram_rd_addr = req_bn_ext[ROW_BW +: ROW_AW];
            end
         end
         SCAN: begin
            ram_wr_en = find.found;
            ram_wr_data = ram_rd_data | (ROW_W'(1) << find.bit_idx);
            ram_rd_en = !find.found && more_rows;
            ram_rd_addr = row_ff + 1'b1;
         end
         FREE_RD: begin
            ram_wr_addr = bn_ext[ROW_BW +: ROW_AW];
            ram_wr_en = ram_rd_data[bn_ff[ROW_BW-1:0]];
            ram_wr_data = ram_rd_data & ~(ROW_W'(1) << bn_ff[ROW_BW-1:0]);
         end
         RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         row_ff <= '0;
         count_ff <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            CLEAR: begin
               row_ff <= row_ff + 1'b1;
               if (row_ff == ROW_AW'(ROWS - 1)) begin
                  state_ff <= IDLE;
               end
            end
            IDLE: begin
               if (accept) begin
                  bn_ff <= req_word.block_number;
                  lim_ff <= lim_in;
                  row_ff <= '0;
                  pend_ff.result_block <= '0;
                  if (req_word.command == CMD_ALLOC) begin
                     if (lim_in == '0) begin
                        pend_ff.status <= ST_FULL;
                        state_ff <= RESP;
                     end else begin
                        state_ff <= SCAN;
                     end
                  end else begin
                     if (req_bn_ext >= lim_in) begin
                        pend_ff.status <= ST_OUT_OF_RANGE;
                        state_ff <= RESP;
                     end else begin
                        state_ff <= FREE_RD;
                     end
                  end
               end
            end
            SCAN: begin
               if (find.found) begin
                  pend_ff.result_block <= grant[BLK_W-1:0];
                  pend_ff.status <= ST_ALLOCATED;
                  state_ff <= RESP;
               end else if (more_rows) begin
                  row_ff <= row_ff + 1'b1;
               end else begin
                  pend_ff.status <= ST_FULL;
                  state_ff <= RESP;
               end
            end
            FREE_RD: begin
               pend_ff.status <= ram_rd_data[bn_ff[ROW_BW-1:0]] ? ST_FREED
                                                               : ST_ALREADY_FREE;
               state_ff <= RESP;
            end
            RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff <= pend_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

endmodule
